// File: hw/rtl/date_time_to_epoch_seconds_core_defines.svh
// Assertion macros for the epoch seconds core.
`ifndef DATE_TIME_TO_EPOCH_SECONDS_CORE_DEFINES_SVH
`define DATE_TIME_TO_EPOCH_SECONDS_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DTES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DTES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/dtes_pkg.sv
package dtes_pkg;

    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 12;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int EPOCH_W  = 37;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam int Q100_W  = 6;
    localparam int TOD_W   = 17;
    localparam int DOY_W   = 9;
    localparam int LEAPS_W = 11;
    localparam int DAYS_W  = 21;

    localparam int RECIP_PROD_W = 25;
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SHIFT = 19;

    localparam logic [TOD_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [TOD_W-1:0] SECS_PER_MIN  = 17'd60;
    localparam logic [EPOCH_W-1:0] SECS_PER_DAY = 37'd86400;
    localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 21'd365;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
    } t_in;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [Q100_W-1:0]  q100;
        logic [TOD_W-1:0]   tod;
        logic [DOY_W-1:0]   dbm;
        logic               month_ok;
    } t_s1;

    typedef struct packed {
        logic               date_ok;
        logic               after_epoch;
        logic [YEAR_W-1:0]  whole;
        logic [LEAPS_W-1:0] leaps_prev;
        logic [DOY_W-1:0]   doy;
        logic [TOD_W-1:0]   tod;
    } t_front;

    typedef struct packed {
        logic              date_ok;
        logic [DAYS_W-1:0] days;
        logic [TOD_W-1:0]  tod;
    } t_days;

    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] d;
        case (m)
            MONTH_JAN: d = 9'd0;
            MONTH_FEB: d = 9'd31;
            MONTH_MAR: d = 9'd59;
            MONTH_APR: d = 9'd90;
            MONTH_MAY: d = 9'd120;
            MONTH_JUN: d = 9'd151;
            MONTH_JUL: d = 9'd181;
            MONTH_AUG: d = 9'd212;
            MONTH_SEP: d = 9'd243;
            MONTH_OCT: d = 9'd273;
            MONTH_NOV: d = 9'd304;
            MONTH_DEC: d = 9'd334;
            default:   d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            MONTH_FEB: n = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 5'd30;
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: n = 5'd31;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

// File: hw/rtl/dtes_front.sv
module dtes_front #(
    parameter int EPOCH_YEAR = 1990
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dtes_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output dtes_pkg::t_front o_data
);

    localparam logic [dtes_pkg::YEAR_W-1:0] EPOCH = dtes_pkg::YEAR_W'(EPOCH_YEAR);

    logic             r_v1;
    logic             r_v2;
    dtes_pkg::t_s1    r_s1;
    dtes_pkg::t_s1    n_s1;
    dtes_pkg::t_front r_s2;
    dtes_pkg::t_front n_s2;
    logic             rdy1;
    logic             rdy2;

    logic [dtes_pkg::RECIP_PROD_W-1:0] q_prod;
    logic [dtes_pkg::YEAR_W-1:0]       cent;
    logic [dtes_pkg::YEAR_W-1:0]       rem100;
    logic                              leap;
    logic [dtes_pkg::LEAPS_W-1:0]      leaps_here;
    logic [dtes_pkg::DAY_W-1:0]        mlen;

    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_s2;

    always_comb begin
        q_prod = dtes_pkg::RECIP_PROD_W'(i_data.year)
               * dtes_pkg::RECIP_PROD_W'(dtes_pkg::RECIP_100);
        n_s1.day      = i_data.day;
        n_s1.month    = i_data.month;
        n_s1.year     = i_data.year;
        n_s1.q100     = q_prod[dtes_pkg::RECIP_SHIFT +: dtes_pkg::Q100_W];
        n_s1.tod      = dtes_pkg::TOD_W'(i_data.hour) * dtes_pkg::SECS_PER_HOUR
                      + dtes_pkg::TOD_W'(i_data.minute) * dtes_pkg::SECS_PER_MIN
                      + dtes_pkg::TOD_W'(i_data.second);
        n_s1.dbm      = dtes_pkg::days_before(i_data.month);
        n_s1.month_ok = i_data.month inside {[dtes_pkg::MONTH_JAN:dtes_pkg::MONTH_DEC]};
    end

    always_comb begin
        cent       = dtes_pkg::YEAR_W'(r_s1.q100) * dtes_pkg::YEAR_W'(100);
        rem100     = r_s1.year - cent;
        leap       = (r_s1.year[1:0] == 2'd0) && ((rem100 != '0) || (r_s1.q100[1:0] == 2'd0));
        leaps_here = dtes_pkg::LEAPS_W'(r_s1.year[dtes_pkg::YEAR_W-1:2])
                   - dtes_pkg::LEAPS_W'(r_s1.q100)
                   + dtes_pkg::LEAPS_W'(r_s1.q100[dtes_pkg::Q100_W-1:2]);
        mlen       = dtes_pkg::month_len(r_s1.month, leap);

        n_s2.date_ok     = r_s1.month_ok && (r_s1.day != '0) && (r_s1.day <= mlen);
        n_s2.after_epoch = r_s1.year > EPOCH;
        n_s2.whole       = r_s1.year - EPOCH;
        n_s2.leaps_prev  = leaps_here - dtes_pkg::LEAPS_W'(leap);
        n_s2.doy         = r_s1.dbm
                         + dtes_pkg::DOY_W'(leap && (r_s1.month > dtes_pkg::MONTH_FEB))
                         + dtes_pkg::DOY_W'(r_s1.day) - 9'd1;
        n_s2.tod         = r_s1.tod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1 <= n_s1;
        end
        if (rdy2 && r_v1) begin
            r_s2 <= n_s2;
        end
    end

endmodule

// File: hw/rtl/dtes_days.sv
module dtes_days #(
    parameter int EPOCH_YEAR = 1990
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  dtes_pkg::t_front i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output dtes_pkg::t_days  o_data
);

    localparam int PREV  = EPOCH_YEAR - 1;
    localparam int LEPOCH = PREV / 4 - PREV / 100 + PREV / 400;

    logic            r_v;
    dtes_pkg::t_days r_d;
    dtes_pkg::t_days n_d;
    logic            rdy;
    logic [dtes_pkg::LEAPS_W-1:0] leap_days;

    assign rdy     = !r_v || i_ready;
    assign o_ready = rdy;
    assign o_valid = r_v;
    assign o_data  = r_d;

    always_comb begin
        leap_days   = i_data.leaps_prev - dtes_pkg::LEAPS_W'(LEPOCH);
        n_d.date_ok = i_data.date_ok;
        n_d.tod     = i_data.tod;
        if (i_data.after_epoch) begin
            n_d.days = dtes_pkg::DAYS_W'(i_data.whole) * dtes_pkg::DAYS_PER_YEAR
                     + dtes_pkg::DAYS_W'(leap_days)
                     + dtes_pkg::DAYS_W'(i_data.doy);
        end else begin
            n_d.days = dtes_pkg::DAYS_W'(i_data.doy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (rdy) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy && i_valid) begin
            r_d <= n_d;
        end
    end

endmodule

// File: hw/rtl/dtes_secs.sv
module dtes_secs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  dtes_pkg::t_days              i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dtes_pkg::EPOCH_W-1:0] o_secs,
    output logic                         o_date_ok
);

    logic                         r_v4;
    logic                         r_v5;
    logic [dtes_pkg::EPOCH_W-1:0] r_prod;
    logic [dtes_pkg::TOD_W-1:0]   r_tod;
    logic                         r_ok4;
    logic [dtes_pkg::EPOCH_W-1:0] r_secs;
    logic                         r_ok5;
    logic [dtes_pkg::EPOCH_W-1:0] n_prod;
    logic [dtes_pkg::EPOCH_W-1:0] n_secs;
    logic                         rdy4;
    logic                         rdy5;

    assign rdy5      = !r_v5 || i_ready;
    assign rdy4      = !r_v4 || rdy5;
    assign o_ready   = rdy4;
    assign o_valid   = r_v5;
    assign o_secs    = r_secs;
    assign o_date_ok = r_ok5;

    assign n_prod = dtes_pkg::EPOCH_W'(i_data.days) * dtes_pkg::SECS_PER_DAY;
    assign n_secs = r_ok4 ? (r_prod + dtes_pkg::EPOCH_W'(r_tod)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy4) begin
                r_v4 <= i_valid;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && i_valid) begin
            r_prod <= n_prod;
            r_tod  <= i_data.tod;
            r_ok4  <= i_data.date_ok;
        end
        if (rdy5 && r_v4) begin
            r_secs <= n_secs;
            r_ok5  <= r_ok4;
        end
    end

endmodule

// File: hw/rtl/date_time_to_epoch_seconds_core.sv
// Throughput: one beat per cycle; every stage holds its beat while the next one is full.
// The pipeline is five registers: year split and time of day, leap and date check,
// day count, day-to-second product, final sum.
// Reset (synchronous, active low) clears all stage valid bits; data registers keep their values.
`include "date_time_to_epoch_seconds_core_defines.svh"

module date_time_to_epoch_seconds_core #(
    parameter int EPOCH_YEAR = 1990
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // day, month, year, hour, minute, second (from bit 0 up), zero padded
    input  logic [dtes_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // epoch_seconds (from bit 0 up), zero padded
    output logic [dtes_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // date_valid
    output logic [0:0]                      o_m_tuser
);

    dtes_pkg::t_in    in_data;
    dtes_pkg::t_front front_data;
    dtes_pkg::t_days  days_data;
    logic             front_valid;
    logic             front_ready;
    logic             days_valid;
    logic             days_ready;
    logic [dtes_pkg::EPOCH_W-1:0] secs;
    logic             date_ok;

    assign in_data   = dtes_pkg::t_in'(i_s_tdata[$bits(dtes_pkg::t_in)-1:0]);
    assign o_m_tdata = dtes_pkg::OUT_DATA_W'(secs);
    assign o_m_tuser = date_ok;

    dtes_front #(
        .EPOCH_YEAR(EPOCH_YEAR)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_tvalid),
        .o_ready(o_s_tready),
        .i_data (in_data),
        .o_valid(front_valid),
        .i_ready(front_ready),
        .o_data (front_data)
    );

    dtes_days #(
        .EPOCH_YEAR(EPOCH_YEAR)
    ) u_days (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(front_valid),
        .o_ready(front_ready),
        .i_data (front_data),
        .o_valid(days_valid),
        .i_ready(days_ready),
        .o_data (days_data)
    );

    dtes_secs u_secs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (days_valid),
        .o_ready  (days_ready),
        .i_data   (days_data),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_secs   (secs),
        .o_date_ok(date_ok)
    );

    `DTES_ASSERT_IMP(a_invalid_is_zero, o_m_tvalid && !o_m_tuser[0], o_m_tdata == '0, "invalid date with nonzero seconds")
    `DTES_ASSERT_IMP(a_full_only_when_held, !o_s_tready, o_m_tvalid && !i_m_tready, "input stalled while output drains")
    `DTES_ASSERT_NEXT(a_full_stays_full, !o_s_tready && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "full pipeline lost a beat")

endmodule

// File: tb/sv/epoch_seconds_checker.sv
`timescale 1ns / 1ps

module epoch_seconds_checker #(
    parameter int EPOCH_YEAR = 1990
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // day, month, year, hour, minute, second (from bit 0 up), zero padded
    input  logic [dtes_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // epoch_seconds (from bit 0 up), zero padded
    input  logic [dtes_pkg::OUT_DATA_W-1:0] i_m_tdata,
    // date_valid
    input  logic [0:0]                      i_m_tuser,
    output int                              o_failures,
    output int                              o_outstanding
);

    typedef struct packed {
        logic [dtes_pkg::EPOCH_W-1:0] secs;
        logic                         date_ok;
    } t_epoch_result;

    t_epoch_result expected_epochs[$];
    t_epoch_result want;

    function automatic int unsigned days_in_month(input logic [dtes_pkg::MONTH_W-1:0] m,
                                                  input logic leap);
        case (m)
            dtes_pkg::MONTH_FEB: return leap ? 29 : 28;
            dtes_pkg::MONTH_APR, dtes_pkg::MONTH_JUN,
            dtes_pkg::MONTH_SEP, dtes_pkg::MONTH_NOV: return 30;
            dtes_pkg::MONTH_JAN, dtes_pkg::MONTH_MAR, dtes_pkg::MONTH_MAY,
            dtes_pkg::MONTH_JUL, dtes_pkg::MONTH_AUG, dtes_pkg::MONTH_OCT,
            dtes_pkg::MONTH_DEC: return 31;
            default: return 0;
        endcase
    endfunction

    function automatic t_epoch_result predict_epoch(input dtes_pkg::t_in ts);
        t_epoch_result    r;
        longint unsigned  days;
        longint unsigned  total;
        int unsigned      y;
        int unsigned      py;
        int unsigned      pe;
        logic             leap;
        logic [dtes_pkg::MONTH_W-1:0] m;
        r = '0;
        y = ts.year;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        if (ts.day == 0 || ts.day > days_in_month(ts.month, leap)) begin
            return r;
        end
        days = 0;
        if (y > EPOCH_YEAR) begin
            py = y - 1;
            pe = EPOCH_YEAR - 1;
            days = longint'(y - EPOCH_YEAR) * 365
                 + (py / 4 - py / 100 + py / 400)
                 - (pe / 4 - pe / 100 + pe / 400);
        end
        for (m = dtes_pkg::MONTH_JAN; m < ts.month; m++) begin
            days += days_in_month(m, leap);
        end
        days += ts.day - 1;
        total = days * 86400 + longint'(ts.hour) * 3600 + longint'(ts.minute) * 60
              + longint'(ts.second);
        r.secs = total[dtes_pkg::EPOCH_W-1:0];
        r.date_ok = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        o_failures++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_epochs.delete();
            o_failures = 0;
            o_outstanding <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_epochs.size() == 0) begin
                    report_mismatch($sformatf("output beat with nothing expected: %0d valid %0b",
                                              i_m_tdata[dtes_pkg::EPOCH_W-1:0], i_m_tuser[0]));
                end else begin
                    want = expected_epochs.pop_front();
                    if (i_m_tdata[dtes_pkg::EPOCH_W-1:0] !== want.secs) begin
                        report_mismatch($sformatf("epoch_seconds %0d, expected %0d",
                                                  i_m_tdata[dtes_pkg::EPOCH_W-1:0],
                                                  want.secs));
                    end
                    if (i_m_tuser[0] !== want.date_ok) begin
                        report_mismatch($sformatf("date_valid %0b, expected %0b",
                                                  i_m_tuser[0], want.date_ok));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_epochs.push_back(
                    predict_epoch(i_s_tdata[$bits(dtes_pkg::t_in)-1:0]));
            end
            o_outstanding <= expected_epochs.size();
        end
    end

endmodule

// File: tb/sv/date_time_to_epoch_seconds_core_tb.sv
`timescale 1ns / 1ps

module date_time_to_epoch_seconds_core_tb;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [dtes_pkg::IN_DATA_W-1:0]  i_s_tdata = '0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [dtes_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic [0:0]                      o_m_tuser;

    int   failures;
    int   outstanding;
    int   stamps_sent = 0;
    logic idle_on = 1'b1;
    int   sink_stall_left = 0;
    int   yr;
    int   mo;
    int   dy;
    int   hr;
    int   mi;
    int   se;

    date_time_to_epoch_seconds_core #(.EPOCH_YEAR(1990)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    epoch_seconds_checker #(.EPOCH_YEAR(1990)) u_epoch_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (i_s_tvalid),
        .i_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .i_m_tdata     (o_m_tdata),
        .i_m_tuser     (o_m_tuser),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            sink_stall_left = $urandom_range(1, 7) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with the valid still high so that back-to-back beats need no extra assignment.
    task automatic send_stamp(input int day, input int month, input int year,
                              input int hour, input int minute, input int second);
        dtes_pkg::t_in                  ts;
        logic [dtes_pkg::IN_DATA_W-1:0] word;
        ts.day    = day[dtes_pkg::DAY_W-1:0];
        ts.month  = month[dtes_pkg::MONTH_W-1:0];
        ts.year   = year[dtes_pkg::YEAR_W-1:0];
        ts.hour   = hour[dtes_pkg::HOUR_W-1:0];
        ts.minute = minute[dtes_pkg::MINUTE_W-1:0];
        ts.second = second[dtes_pkg::SECOND_W-1:0];
        word = '0;
        word[$bits(dtes_pkg::t_in)-1:0] = ts;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= word;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        stamps_sent++;
    endtask

    initial begin
        #400000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_stamp(1, dtes_pkg::MONTH_JAN, 1990, 0, 0, 0);
        send_stamp(31, dtes_pkg::MONTH_DEC, 1989, 23, 59, 59);
        send_stamp(1, dtes_pkg::MONTH_JAN, 1991, 0, 0, 0);
        send_stamp(29, dtes_pkg::MONTH_FEB, 1990, 12, 0, 0);
        send_stamp(29, dtes_pkg::MONTH_FEB, 2000, 1, 2, 3);
        send_stamp(1, dtes_pkg::MONTH_MAR, 2000, 0, 0, 0);
        send_stamp(29, dtes_pkg::MONTH_FEB, 1900, 0, 0, 0);
        send_stamp(29, dtes_pkg::MONTH_FEB, 2024, 6, 30, 15);
        send_stamp(29, dtes_pkg::MONTH_FEB, 2023, 6, 30, 15);
        send_stamp(28, dtes_pkg::MONTH_FEB, 2100, 23, 59, 59);
        send_stamp(1, dtes_pkg::MONTH_MAR, 2100, 0, 0, 0);
        send_stamp(29, dtes_pkg::MONTH_FEB, 0, 0, 0, 0);
        send_stamp(1, dtes_pkg::MONTH_JAN, 0, 0, 0, 0);
        send_stamp(31, dtes_pkg::MONTH_DEC, 4095, 31, 63, 63);
        send_stamp(1, dtes_pkg::MONTH_JAN, 4095, 0, 0, 0);
        send_stamp(15, 0, 2000, 0, 0, 0);
        send_stamp(15, 13, 2000, 0, 0, 0);
        send_stamp(31, 15, 4095, 31, 63, 63);
        send_stamp(0, dtes_pkg::MONTH_JUN, 2000, 0, 0, 0);
        send_stamp(31, dtes_pkg::MONTH_APR, 2010, 0, 0, 0);
        send_stamp(30, dtes_pkg::MONTH_APR, 2010, 0, 0, 0);
        send_stamp(31, dtes_pkg::MONTH_JAN, 1991, 31, 63, 63);
        send_stamp(31, dtes_pkg::MONTH_DEC, 2399, 23, 59, 59);
        send_stamp(31, dtes_pkg::MONTH_AUG, 1600, 10, 20, 30);

        for (int i = 0; i < 1500; i++) begin
            idle_on = (i < 1300);
            if (i == 700) begin
                i_s_tvalid <= 1'b0;
                while (outstanding != 0) @(negedge i_clk);
            end
            if ($urandom_range(0, 9) < 3) begin
                yr = $urandom_range(0, 4095);
                mo = $urandom_range(0, 15);
                dy = $urandom_range(0, 31);
                hr = $urandom_range(0, 31);
                mi = $urandom_range(0, 63);
                se = $urandom_range(0, 63);
            end else begin
                case ($urandom_range(0, 3))
                    0: yr = $urandom_range(0, 4095);
                    1: yr = $urandom_range(1980, 2100);
                    2: yr = 100 * $urandom_range(0, 40) + $urandom_range(0, 4);
                    default: yr = 4 * $urandom_range(0, 1023);
                endcase
                mo = $urandom_range(dtes_pkg::MONTH_JAN, dtes_pkg::MONTH_DEC);
                dy = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 28)
                                                : $urandom_range(29, 31);
                hr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23);
                mi = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
                se = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59);
            end
            send_stamp(dy, mo, yr, hr, mi, se);
        end

        i_s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (12) @(negedge i_clk);

        $display("Sent %0d timestamps: leap-day, century, epoch-edge and invalid-date cases,",
                 stamps_sent);
        $display("then random dates over years 0 to 4095 with stall bursts on both sides.");
        if (failures == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/dtes_pkg.sv
hw/rtl/dtes_front.sv
hw/rtl/dtes_days.sv
hw/rtl/dtes_secs.sv
hw/rtl/date_time_to_epoch_seconds_core.sv
tb/sv/epoch_seconds_checker.sv
tb/sv/date_time_to_epoch_seconds_core_tb.sv
